### design/stt_pkg.sv
package stt_pkg;

    localparam int KEY_W         = 64;
    localparam int DEPTH_W       = 7;
    localparam int SCORE_W       = 18;
    localparam int MOVE_W        = 7;
    localparam int FLAG_W        = 2;
    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    localparam logic [IDX_W-1:0]         LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic signed [MOVE_W-1:0] MOVE_NONE = '1;

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_STORE  = 2'd1,
        KIND_CLEAR  = 2'd2
    } t_kind;

    typedef enum logic [FLAG_W-1:0] {
        FLAG_EXACT = 2'd0,
        FLAG_UPPER = 2'd1,
        FLAG_LOWER = 2'd2
    } t_flag;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_EXEC
    } t_state;

    // one table slot as held in the memory
    typedef struct packed {
        logic                valid;
        logic [KEY_W-1:0]    key;
        logic [SCORE_W-1:0]  score;
        logic [MOVE_W-1:0]   move;
        logic [DEPTH_W-1:0]  depth;
        logic [FLAG_W-1:0]   flag;
    } t_entry;

    // captured request
    typedef struct packed {
        logic [1:0]          kind;
        logic [KEY_W-1:0]    key;
        logic [DEPTH_W-1:0]  depth;
        logic [SCORE_W-1:0]  alpha;
        logic [SCORE_W-1:0]  beta;
        logic [SCORE_W-1:0]  score;
        logic [MOVE_W-1:0]   move;
    } t_req;

endpackage

### design/stt_req_if.sv
interface stt_req_if import stt_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [1:0]                 kind;
    logic [KEY_W-1:0]           key;
    logic [DEPTH_W-1:0]         depth;
    logic signed [SCORE_W-1:0]  alpha;
    logic signed [SCORE_W-1:0]  beta;
    logic signed [SCORE_W-1:0]  store_score;
    logic signed [MOVE_W-1:0]   store_move;

    modport source (
        output valid, kind, key, depth, alpha, beta, store_score, store_move,
        input  ready
    );
    modport sink (
        input  valid, kind, key, depth, alpha, beta, store_score, store_move,
        output ready
    );
endinterface

### design/stt_rsp_if.sv
interface stt_rsp_if import stt_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic                       key_matched;
    logic signed [SCORE_W-1:0]  found_score;
    logic signed [MOVE_W-1:0]   found_move;

    modport source (
        output valid, hit, key_matched, found_score, found_move,
        input  ready
    );
    modport sink (
        input  valid, hit, key_matched, found_score, found_move,
        output ready
    );
endinterface

### design/search_transposition_table_top.sv
// direct-mapped, depth-preferred transposition table: each request transfer is a lookup, a
// store or a whole-table clear, addressed by the low bits of the 64-bit key, and gives exactly
// one response transfer; all slots live in one single-port-write, registered-read memory, so
// an item is read from its slot first and then compared, answered and written back; no new
// request is taken before the previous one has been answered, and the response register lets
// that answer wait; a clear, and reset itself, run a sweep over all TABLE_ENTRIES slots (1024)
// that writes every slot invalid, during which no request is taken; an invalid slot reads as
// all zeros, so a lookup of key 0 in an empty slot matches with move 0
module search_transposition_table_top import stt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stt_req_if.sink    i_req,
    stt_rsp_if.source  o_rsp
);

    // slot memory and its registered read port
    t_entry r_mem [TABLE_ENTRIES];
    t_entry r_rd;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_sweep_idx, n_sweep_idx;
    t_req             r_req;

    logic                       r_out_valid;
    logic                       r_hit;
    logic                       r_key_matched;
    logic signed [SCORE_W-1:0]  r_found_score;
    logic signed [MOVE_W-1:0]   r_found_move;

    // control decoded from the state
    logic             req_ready;
    logic             mem_rd_en;
    logic             mem_we;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;
    logic             load_out;
    logic             out_free;

    // slot as seen after masking with its valid bit
    t_entry                     slot;
    logic signed [SCORE_W-1:0]  slot_score;
    logic signed [SCORE_W-1:0]  req_alpha;
    logic signed [SCORE_W-1:0]  req_beta;
    logic signed [SCORE_W-1:0]  req_score;
    logic                       key_eq;
    logic                       depth_ok;
    logic                       flag_ok;
    logic                       store_ok;
    logic [FLAG_W-1:0]          new_flag;

    // per-kind answer
    logic                       res_hit;
    logic                       res_key_matched;
    logic signed [SCORE_W-1:0]  res_score;
    logic signed [MOVE_W-1:0]   res_move;

    assign out_free   = !r_out_valid || o_rsp.ready;
    assign slot       = r_rd.valid ? r_rd : '0;
    assign slot_score = signed'(slot.score);
    assign req_alpha  = signed'(r_req.alpha);
    assign req_beta   = signed'(r_req.beta);
    assign req_score  = signed'(r_req.score);
    assign key_eq     = slot.key == r_req.key;
    assign depth_ok   = slot.depth >= r_req.depth;

    // bound flag decides whether the stored score settles the window
    always_comb begin
        unique case (slot.flag)
            FLAG_EXACT: flag_ok = 1'b1;
            FLAG_UPPER: flag_ok = slot_score <= req_alpha;
            FLAG_LOWER: flag_ok = slot_score >= req_beta;
            default:    flag_ok = 1'b0;
        endcase
    end

    // depth-preferred replacement: keep a deeper result for the same position
    assign store_ok = !(r_rd.valid && key_eq && (slot.depth > r_req.depth));

    always_comb begin
        priority if (req_score <= req_alpha) begin
            new_flag = FLAG_UPPER;
        end else if (req_score >= req_beta) begin
            new_flag = FLAG_LOWER;
        end else begin
            new_flag = FLAG_EXACT;
        end
    end

    always_comb begin
        res_hit         = 1'b0;
        res_key_matched = 1'b0;
        res_score       = '0;
        res_move        = MOVE_NONE;
        unique case (r_req.kind)
            KIND_LOOKUP: begin
                if (key_eq) begin
                    res_key_matched = 1'b1;
                    res_move        = signed'(slot.move);
                    if (depth_ok && flag_ok) begin
                        res_hit   = 1'b1;
                        res_score = slot_score;
                    end
                end
            end
            default: begin
                // store, clear and the unused code answer with an empty result
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_SWEEP: begin
                if (r_sweep_idx == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_state = (r_req.kind == KIND_CLEAR) ? ST_SWEEP : ST_IDLE;
                end
            end
            default: n_state = ST_SWEEP;
        endcase
    end

    // state outputs
    always_comb begin
        req_ready = 1'b0;
        mem_rd_en = 1'b0;
        mem_we    = 1'b0;
        wr_addr   = r_req.key[IDX_W-1:0];
        wr_data   = '0;
        load_out  = 1'b0;
        unique case (r_state)
            ST_SWEEP: begin
                mem_we  = 1'b1;
                wr_addr = r_sweep_idx;
            end
            ST_IDLE: begin
                req_ready = 1'b1;
                mem_rd_en = i_req.valid;
            end
            ST_EXEC: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (r_req.kind == KIND_STORE && store_ok) begin
                        mem_we        = 1'b1;
                        wr_data.valid = 1'b1;
                        wr_data.key   = r_req.key;
                        wr_data.score = r_req.score;
                        wr_data.move  = r_req.move;
                        wr_data.depth = r_req.depth;
                        wr_data.flag  = new_flag;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign n_sweep_idx = (r_state == ST_SWEEP) ? r_sweep_idx + 1'b1 : '0;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_rd_en) begin
            r_rd <= r_mem[i_req.key[IDX_W-1:0]];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_sweep_idx <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep_idx <= n_sweep_idx;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request capture and response payload
    always_ff @(posedge i_clk) begin
        if (mem_rd_en) begin
            r_req.kind  <= i_req.kind;
            r_req.key   <= i_req.key;
            r_req.depth <= i_req.depth;
            r_req.alpha <= i_req.alpha;
            r_req.beta  <= i_req.beta;
            r_req.score <= i_req.store_score;
            r_req.move  <= i_req.store_move;
        end
        if (load_out) begin
            r_hit         <= res_hit;
            r_key_matched <= res_key_matched;
            r_found_score <= res_score;
            r_found_move  <= res_move;
        end
    end

    assign i_req.ready       = req_ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.hit         = r_hit;
    assign o_rsp.key_matched = r_key_matched;
    assign o_rsp.found_score = r_found_score;
    assign o_rsp.found_move  = r_found_move;

    // a transfer always moves straight to the compare cycle
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == ST_EXEC))
        else $error("accepted request did not reach compare cycle");

    // outside the sweep, only a store writes the memory
    a_write_only_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && r_state != ST_SWEEP) |-> (r_req.kind == KIND_STORE))
        else $error("memory written by a non-store request");

    // a response appears only out of a compare cycle
    a_rsp_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_EXEC))
        else $error("response raised outside compare cycle");

    // a hit always comes with a key match
    a_hit_matched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.hit) |-> o_rsp.key_matched)
        else $error("hit reported without key match");

endmodule
